// ----- rtl/rgb_to_hsv_converter_defines.svh -----
// assertion macros for the rgb to hsv converter
// no dependencies; taken in by the files that carry assertions
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

`ifndef ASSERT_OFF

`define RGBHSV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define RGBHSV_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    `RGBHSV_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`define RGBHSV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    `RGBHSV_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`else

`define RGBHSV_ASSERT(lbl, clk, rst_n, prop, msg)
`define RGBHSV_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define RGBHSV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/rgbhsv_pkg.sv -----
// shared widths, constants and pipeline types of the rgb to hsv converter
// no dependencies
`timescale 1ns / 1ps

package rgbhsv_pkg;

    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int QUO_W      = CH_W + 1;       // hue quotient reaches 256
    localparam int NUM_W      = 2 * CH_W;       // dividend width
    localparam int HUE_W      = 11;
    localparam int HUE_SECTOR = 256;
    localparam int HUE_TURN   = 1536;

    localparam logic [HUE_W-1:0] BASE_RED   = HUE_W'(0);
    localparam logic [HUE_W-1:0] BASE_GREEN = HUE_W'(2 * HUE_SECTOR);
    localparam logic [HUE_W-1:0] BASE_BLUE  = HUE_W'(4 * HUE_SECTOR);

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } t_sector;

    // one restoring divider lane: partial remainder, dividend bits still to
    // shift in, divisor and quotient bits so far
    typedef struct packed {
        logic [CH_W-1:0]  rem;
        logic [QUO_W-1:0] low;
        logic [CH_W-1:0]  div;
        logic [QUO_W-1:0] quo;
    } t_div_lane;

    typedef struct packed {
        t_sector         sector;
        logic            neg;
        logic            grey;
        logic            black;
        logic [CH_W-1:0] brightness;
    } t_side;

    typedef struct packed {
        t_div_lane sat;
        t_div_lane hue;
        t_side     side;
    } t_cell_data;

endpackage

// ----- rtl/rgbhsv_if.sv -----
// stream interfaces for pixels in and hsv results out
// depends on rgbhsv_pkg
`timescale 1ns / 1ps

interface rgbhsv_in_if;
    logic                       valid;
    logic                       ready;
    logic [rgbhsv_pkg::PIX_W-1:0] pixel_rgb;

    modport source (output valid, output pixel_rgb, input ready);
    modport sink   (input valid, input pixel_rgb, output ready);
endinterface

interface rgbhsv_out_if;
    logic                       valid;
    logic                       ready;
    logic [rgbhsv_pkg::HUE_W-1:0] hue;
    logic [rgbhsv_pkg::CH_W-1:0]  saturation;
    logic [rgbhsv_pkg::CH_W-1:0]  brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

// ----- rtl/rgbhsv_front.sv -----
// front stage: max, min, sector, hue difference and both dividends
// depends on rgbhsv_pkg
`timescale 1ns / 1ps

module rgbhsv_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [rgbhsv_pkg::PIX_W-1:0] i_pixel_rgb,
    output logic                         o_valid,
    output rgbhsv_pkg::t_cell_data       o_data
);
    import rgbhsv_pkg::*;

    logic [CH_W-1:0]  red, green, blue;
    logic [CH_W-1:0]  mx, mn, d, pa, pb, mag;
    logic [NUM_W-1:0] sat_num, hue_num;
    t_sector          sector;
    logic             neg;
    t_cell_data       n_data;
    t_cell_data       r_data;
    logic             r_valid;

    assign red   = i_pixel_rgb[PIX_W-1 -: CH_W];
    assign green = i_pixel_rgb[2*CH_W-1 -: CH_W];
    assign blue  = i_pixel_rgb[CH_W-1:0];

    always_comb begin
        mx = red;
        if (green > mx) mx = green;
        if (blue > mx) mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn) mn = blue;
        d = mx - mn;

        // red wins ties, then green
        priority if (mx == red) begin
            sector = SECT_RED;
        end else if (mx == green) begin
            sector = SECT_GREEN;
        end else begin
            sector = SECT_BLUE;
        end

        unique case (sector)
            SECT_RED: begin
                pa = green;
                pb = blue;
            end
            SECT_GREEN: begin
                pa = blue;
                pb = red;
            end
            SECT_BLUE: begin
                pa = red;
                pb = green;
            end
            default: begin
                pa = '0;
                pb = '0;
            end
        endcase

        neg = pa < pb;
        mag = neg ? (pb - pa) : (pa - pb);

        // d*255 + max/2, and mag*256
        sat_num = {d, {CH_W{1'b0}}} - {{CH_W{1'b0}}, d} + {{(CH_W+1){1'b0}}, mx[CH_W-1:1]};
        hue_num = {mag, {CH_W{1'b0}}};

        // quotients stay below 2^QUO_W, so the upper dividend bits are below the divisor
        n_data.sat.rem = CH_W'(sat_num[NUM_W-1:QUO_W]);
        n_data.sat.low = sat_num[QUO_W-1:0];
        n_data.sat.div = mx;
        n_data.sat.quo = '0;
        n_data.hue.rem = CH_W'(hue_num[NUM_W-1:QUO_W]);
        n_data.hue.low = hue_num[QUO_W-1:0];
        n_data.hue.div = d;
        n_data.hue.quo = '0;

        n_data.side.sector     = sector;
        n_data.side.neg        = neg;
        n_data.side.grey       = (d == '0);
        n_data.side.black      = (mx == '0);
        n_data.side.brightness = mx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- rtl/rgbhsv_cell.sv -----
// one divider cell: a quotient bit for the saturation and the hue lane
// depends on rgbhsv_pkg
`timescale 1ns / 1ps

module rgbhsv_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  rgbhsv_pkg::t_cell_data i_data,
    output logic                   o_valid,
    output rgbhsv_pkg::t_cell_data o_data
);
    import rgbhsv_pkg::*;

    t_cell_data n_data;
    t_cell_data r_data;
    logic       r_valid;

    // shift in the next dividend bit, subtract the divisor when it fits
    function automatic t_div_lane div_step(input t_div_lane lane);
        t_div_lane       res;
        logic [CH_W:0]   trial;
        logic [CH_W:0]   diff;
        logic            fits;
        trial = {lane.rem, lane.low[QUO_W-1]};
        diff  = trial - {1'b0, lane.div};
        fits  = trial >= {1'b0, lane.div};
        res.rem = fits ? diff[CH_W-1:0] : trial[CH_W-1:0];
        res.low = {lane.low[QUO_W-2:0], 1'b0};
        res.div = lane.div;
        res.quo = {lane.quo[QUO_W-2:0], fits};
        return res;
    endfunction

    always_comb begin
        n_data.sat  = div_step(i_data.sat);
        n_data.hue  = div_step(i_data.hue);
        n_data.side = i_data.side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- rtl/rgbhsv_back.sv -----
// back stage: hue assembly and wrap, output register and skid buffer
// depends on rgbhsv_pkg, rgbhsv_if and the assertion macro header
`timescale 1ns / 1ps
`include "rgb_to_hsv_converter_defines.svh"

module rgbhsv_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  rgbhsv_pkg::t_cell_data i_data,
    output logic                   o_en,
    rgbhsv_out_if.source           o_hsv
);
    import rgbhsv_pkg::*;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  brightness;
    } t_result;

    logic [HUE_W-1:0] base;
    logic [HUE_W:0]   sum;
    logic [HUE_W:0]   wrapped;
    t_result          n_out;
    t_result          r_out;
    t_result          r_skid;
    logic             r_valid;
    logic             r_skid_full;
    logic             en;

    assign en = !r_skid_full;

    always_comb begin
        unique case (i_data.side.sector)
            SECT_RED:   base = BASE_RED;
            SECT_GREEN: base = BASE_GREEN;
            SECT_BLUE:  base = BASE_BLUE;
            default:    base = BASE_RED;
        endcase

        if (i_data.side.neg) begin
            sum = {1'b0, base} - (HUE_W+1)'(i_data.hue.quo);
        end else begin
            sum = {1'b0, base} + (HUE_W+1)'(i_data.hue.quo);
        end

        // sum below zero wraps up one turn, at or above a turn wraps down
        if (sum[HUE_W]) begin
            wrapped = sum + (HUE_W+1)'(HUE_TURN);
        end else if (sum >= (HUE_W+1)'(HUE_TURN)) begin
            wrapped = sum - (HUE_W+1)'(HUE_TURN);
        end else begin
            wrapped = sum;
        end

        n_out.hue        = i_data.side.grey ? '0 : wrapped[HUE_W-1:0];
        n_out.saturation = i_data.side.black ? '0 : i_data.sat.quo[CH_W-1:0];
        n_out.brightness = i_data.side.brightness;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_skid_full <= 1'b0;
        end else begin
            if (en) begin
                r_valid <= i_valid;
            end
            if (r_skid_full) begin
                if (o_hsv.ready) begin
                    r_skid_full <= 1'b0;
                end
            end else if (r_valid && !o_hsv.ready) begin
                r_skid_full <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
        if (!r_skid_full) begin
            r_skid <= r_out;
        end
    end

    assign o_en             = en;
    assign o_hsv.valid      = r_skid_full || r_valid;
    assign o_hsv.hue        = r_skid_full ? r_skid.hue : r_out.hue;
    assign o_hsv.saturation = r_skid_full ? r_skid.saturation : r_out.saturation;
    assign o_hsv.brightness = r_skid_full ? r_skid.brightness : r_out.brightness;

    `RGBHSV_ASSERT_NEXT(a_stalled_result_kept, i_clk, i_rst_n,
        r_valid && !o_hsv.ready && !r_skid_full, r_skid_full, "stalled result was dropped")
    `RGBHSV_ASSERT_IMPLY(a_hue_in_turn, i_clk, i_rst_n,
        o_hsv.valid, o_hsv.hue < (HUE_W+1)'(HUE_TURN), "hue outside one turn")
    `RGBHSV_ASSERT_IMPLY(a_black_is_grey, i_clk, i_rst_n,
        o_hsv.valid && o_hsv.brightness == '0,
        o_hsv.saturation == '0 && o_hsv.hue == '0, "black pixel with hue or saturation")
    `RGBHSV_ASSERT_IMPLY(a_unsaturated_no_hue, i_clk, i_rst_n,
        o_hsv.valid && o_hsv.saturation == '0, o_hsv.hue == '0, "grey pixel with hue")

endmodule

// ----- rtl/rgb_to_hsv_converter.sv -----
// top level of the rgb to hsv converter: front stage, divider cell chain, back stage
// depends on rgbhsv_pkg, rgbhsv_if, rgbhsv_front, rgbhsv_cell and rgbhsv_back
`timescale 1ns / 1ps

// Converts one packed 24-bit RGB pixel per clock into hue (0..1535, 256 steps per
// 60-degree sector), saturation (0..255) and value (the largest channel). The block
// takes a pixel every cycle while the result side keeps up. Each result is registered
// in the front stage after max/min and the dividends, then in each of a chain of nine
// divider cells that each resolve one quotient bit of the saturation and the hue
// division, and last in the back stage after hue assembly. A two-entry
// output stage lets the last result wait while the input still takes a pixel; a
// stall on the output stops the whole pipeline only once that stage is full.
module rgb_to_hsv_converter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rgbhsv_in_if.sink     i_pix,
    rgbhsv_out_if.source  o_hsv
);
    import rgbhsv_pkg::*;

    t_cell_data chain_data  [QUO_W+1];
    logic       chain_valid [QUO_W+1];
    logic       en;

    assign i_pix.ready = en;

    rgbhsv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_pix.valid),
        .i_pixel_rgb (i_pix.pixel_rgb),
        .o_valid     (chain_valid[0]),
        .o_data      (chain_data[0])
    );

    for (genvar k = 0; k < QUO_W; k++) begin : g_cell
        rgbhsv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (chain_valid[k]),
            .i_data  (chain_data[k]),
            .o_valid (chain_valid[k+1]),
            .o_data  (chain_data[k+1])
        );
    end

    rgbhsv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chain_valid[QUO_W]),
        .i_data  (chain_data[QUO_W]),
        .o_en    (en),
        .o_hsv   (o_hsv)
    );

endmodule
